FILE: design/esu_pkg.sv
// Shared types and constants of the escape sequence unescaper.
package esu_pkg;

  // Characters of an escape still being collected, and replay list depth.
  localparam int unsigned HELD_DEPTH   = 5;
  localparam int unsigned HELD_AW      = $clog2(HELD_DEPTH);
  localparam int unsigned HELD_CW      = $clog2(HELD_DEPTH + 1);
  localparam int unsigned REPLAY_DEPTH = 4;
  localparam int unsigned REPLAY_CW    = $clog2(REPLAY_DEPTH + 1);
  localparam int unsigned MAX_RESULTS  = 4;
  localparam int unsigned RES_CW       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HEX_DIGITS   = 2;
  localparam int unsigned UNI_DIGITS   = 4;
  localparam int unsigned CP_W         = 4 * UNI_DIGITS;

  // ASCII codes the decoder reacts to.
  localparam logic [7:0] ASC_BSL   = 8'h5C;
  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_THREE = 8'h33;
  localparam logic [7:0] ASC_X     = 8'h78;
  localparam logic [7:0] ASC_U     = 8'h75;
  localparam logic [7:0] ASC_E     = 8'h65;
  localparam logic [7:0] ASC_N     = 8'h6E;
  localparam logic [7:0] ASC_T     = 8'h74;
  localparam logic [7:0] ASC_DIG0  = 8'h30;
  localparam logic [7:0] ASC_DIG9  = 8'h39;
  localparam logic [7:0] ASC_LA    = 8'h61;
  localparam logic [7:0] ASC_LF    = 8'h66;
  localparam logic [7:0] ASC_UA    = 8'h41;
  localparam logic [7:0] ASC_UF    = 8'h46;

  // Bytes produced by the named escapes.
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_NL  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // UTF-8 encoding limits and marker bits.
  localparam logic [CP_W-1:0] UTF8_ONE_MAX = 16'h007F;
  localparam logic [CP_W-1:0] UTF8_TWO_MAX = 16'h07FF;
  localparam logic [7:0]      UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]      UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]      UTF8_CONT    = 8'h80;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_BSL,
    CLS_ZERO,
    CLS_THREE,
    CLS_X,
    CLS_U,
    CLS_E,
    CLS_N,
    CLS_T
  } chr_cls_e;

  // One character together with its classification.
  typedef struct packed {
    logic [7:0] code;
    chr_cls_e   cls;
    logic       hex_ok;
    logic [3:0] nib;
  } char_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
    logic       hex_error;
  } res_t;

endpackage

FILE: design/esu_in_if.sv
// Input channel of the unescaper: one character per beat.
interface esu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: design/esu_out_if.sv
// Output channel of the unescaper: one decoded result per beat.
interface esu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_end;
  logic       hex_error;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output string_end, output hex_error, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input string_end, input hex_error, output ready);
endinterface

FILE: design/esu_front.sv
// Front end: takes input beats and classifies each character.
module esu_front (
  esu_in_if.sink          in_i,
  output logic            push_valid_o,
  output esu_pkg::item_t  push_item_o,
  input  logic            push_ready_i
);

  esu_pkg::chr_cls_e cls;
  logic              hex_ok;
  logic [3:0]        nib;
  logic [7:0]        c;

  assign c = in_i.in_byte;

  always_comb begin
    unique case (c)
      esu_pkg::ASC_BSL:   cls = esu_pkg::CLS_BSL;
      esu_pkg::ASC_ZERO:  cls = esu_pkg::CLS_ZERO;
      esu_pkg::ASC_THREE: cls = esu_pkg::CLS_THREE;
      esu_pkg::ASC_X:     cls = esu_pkg::CLS_X;
      esu_pkg::ASC_U:     cls = esu_pkg::CLS_U;
      esu_pkg::ASC_E:     cls = esu_pkg::CLS_E;
      esu_pkg::ASC_N:     cls = esu_pkg::CLS_N;
      esu_pkg::ASC_T:     cls = esu_pkg::CLS_T;
      default:            cls = esu_pkg::CLS_OTHER;
    endcase
  end

  // Letters a-f and A-F carry their value minus nine in the low nibble.
  always_comb begin
    hex_ok = 1'b0;
    nib    = c[3:0];
    if (c >= esu_pkg::ASC_DIG0 && c <= esu_pkg::ASC_DIG9) begin
      hex_ok = 1'b1;
    end else if ((c >= esu_pkg::ASC_LA && c <= esu_pkg::ASC_LF) ||
                 (c >= esu_pkg::ASC_UA && c <= esu_pkg::ASC_UF)) begin
      hex_ok = 1'b1;
      nib    = 4'(c[3:0] + 4'd9);
    end
  end

  assign push_valid_o        = in_i.valid;
  assign in_i.ready          = push_ready_i;
  assign push_item_o.ch.code   = c;
  assign push_item_o.ch.cls    = cls;
  assign push_item_o.ch.hex_ok = hex_ok;
  assign push_item_o.ch.nib    = nib;
  assign push_item_o.last      = in_i.in_last;

endmodule

FILE: design/esu_queue.sv
// Short queue of classified characters between the front and back ends.
module esu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  esu_pkg::item_t  push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output esu_pkg::item_t  pop_item_o,
  input  logic            pop_ready_i
);

  esu_pkg::item_t                    mem_q [esu_pkg::QUEUE_DEPTH];
  logic [esu_pkg::QUEUE_AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [esu_pkg::QUEUE_AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [esu_pkg::QUEUE_CW-1:0]      cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign push_ready_o = (cnt_q != esu_pkg::QUEUE_CW'(esu_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == esu_pkg::QUEUE_AW'(esu_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 esu_pkg::QUEUE_AW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == esu_pkg::QUEUE_AW'(esu_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 esu_pkg::QUEUE_AW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = esu_pkg::QUEUE_CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = esu_pkg::QUEUE_CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: design/esu_back.sv
// Back end: decode sequencer, result grouping and output register.
module esu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  esu_pkg::item_t  q_item_i,
  output logic            q_ready_o,
  esu_out_if.source       out_o
);

  typedef enum logic {S_IDLE, S_RUN} state_e;
  typedef enum logic [2:0] {M_PLAIN, M_BSL, M_ZERO, M_HEX, M_UNI} mode_e;

  state_e                          state_q, state_d;
  mode_e                           mode_q, mode_d;
  logic [esu_pkg::HELD_CW-1:0]     hcnt_q, hcnt_d;
  logic [esu_pkg::REPLAY_CW-1:0]   rlen_q, rlen_d;
  logic                            last_q, last_d;
  logic [1:0]                      emit_q, emit_d;
  logic [esu_pkg::RES_CW-1:0]      pcnt_q, pcnt_d;
  logic                            pend_vld_q, pend_vld_d;
  logic                            out_vld_q, out_vld_d;
  esu_pkg::res_t                   out_q, out_d;
  esu_pkg::res_t                   pend_q, pend_d;
  logic [esu_pkg::CP_W-1:0]        ucp_q, ucp_d;
  esu_pkg::char_t                  held_q [esu_pkg::HELD_DEPTH];
  esu_pkg::char_t                  held_d [esu_pkg::HELD_DEPTH];
  esu_pkg::char_t                  rep_q  [esu_pkg::REPLAY_DEPTH];
  esu_pkg::char_t                  rep_d  [esu_pkg::REPLAY_DEPTH];

  esu_pkg::char_t                  head;
  esu_pkg::char_t                  digs [esu_pkg::UNI_DIGITS];
  logic [esu_pkg::CP_W-1:0]        hv;
  logic                            hrun;
  logic                            uni;
  logic                            can_enq;
  logic                            push, enq, q_ready;
  esu_pkg::res_t                   push_res, enq_res;

  assign head    = rep_q[0];
  assign uni     = (mode_q == M_UNI);
  assign can_enq = !out_vld_q || out_o.ready;

  // Value of the leading hex digits of a finishing \x or \u escape.
  always_comb begin
    digs[0] = held_q[2];
    for (int k = 1; k < esu_pkg::UNI_DIGITS; k++) begin
      digs[k] = head;
    end
    if (uni) begin
      digs[1] = held_q[3];
      digs[2] = held_q[4];
    end
    hv   = '0;
    hrun = 1'b1;
    for (int k = 0; k < esu_pkg::UNI_DIGITS; k++) begin
      if (k < (uni ? esu_pkg::UNI_DIGITS : esu_pkg::HEX_DIGITS) && hrun && digs[k].hex_ok) begin
        hv = {hv[esu_pkg::CP_W-5:0], digs[k].nib};
      end else begin
        hrun = 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    hcnt_d     = hcnt_q;
    rlen_d     = rlen_q;
    last_d     = last_q;
    emit_d     = emit_q;
    pcnt_d     = pcnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    ucp_d      = ucp_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    held_d     = held_q;
    rep_d      = rep_q;
    push       = 1'b0;
    push_res   = '0;
    enq        = 1'b0;
    enq_res    = '0;
    q_ready    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid_i) begin
          rep_d[0] = q_item_i.ch;
          rlen_d   = esu_pkg::REPLAY_CW'(1);
          last_d   = q_item_i.last;
          state_d  = S_RUN;
        end
      end
      S_RUN: begin
        if (can_enq) begin
          priority if (emit_q != 2'd0) begin
            // Trailing continuation bytes of a UTF-8 sequence.
            push                = 1'b1;
            push_res.byte_valid = 1'b1;
            push_res.out_byte   = (emit_q == 2'd2) ?
                                  (esu_pkg::UTF8_CONT | {2'b00, ucp_q[11:6]}) :
                                  (esu_pkg::UTF8_CONT | {2'b00, ucp_q[5:0]});
            emit_d              = 2'(emit_q - 2'd1);
          end else if (rlen_q != '0) begin
            // Feed the head of the replay list; by default it is consumed.
            for (int k = 0; k < esu_pkg::REPLAY_DEPTH - 1; k++) begin
              rep_d[k] = rep_q[k + 1];
            end
            rlen_d              = esu_pkg::REPLAY_CW'(rlen_q - 1'b1);
            push_res.byte_valid = 1'b1;
            unique case (mode_q)
              M_PLAIN: begin
                if (head.cls == esu_pkg::CLS_BSL) begin
                  held_d[0] = head;
                  hcnt_d    = esu_pkg::HELD_CW'(1);
                  mode_d    = M_BSL;
                end else begin
                  push              = 1'b1;
                  push_res.out_byte = head.code;
                end
              end
              M_BSL: begin
                if (head.cls == esu_pkg::CLS_ZERO || head.cls == esu_pkg::CLS_X ||
                    head.cls == esu_pkg::CLS_U) begin
                  held_d[1] = head;
                  hcnt_d    = esu_pkg::HELD_CW'(2);
                  mode_d    = (head.cls == esu_pkg::CLS_ZERO) ? M_ZERO :
                              (head.cls == esu_pkg::CLS_X)    ? M_HEX  : M_UNI;
                end else begin
                  mode_d = M_PLAIN;
                  hcnt_d = '0;
                  push   = 1'b1;
                  unique case (head.cls)
                    esu_pkg::CLS_E: push_res.out_byte = esu_pkg::BYTE_ESC;
                    esu_pkg::CLS_N: push_res.out_byte = esu_pkg::BYTE_NL;
                    esu_pkg::CLS_T: push_res.out_byte = esu_pkg::BYTE_TAB;
                    default:        push_res.out_byte = head.code;
                  endcase
                end
              end
              M_ZERO: begin
                if (head.cls == esu_pkg::CLS_THREE) begin
                  if (hcnt_q >= esu_pkg::HELD_CW'(3)) begin
                    mode_d            = M_PLAIN;
                    hcnt_d            = '0;
                    push              = 1'b1;
                    push_res.out_byte = esu_pkg::BYTE_ESC;
                  end else begin
                    held_d[hcnt_q[esu_pkg::HELD_AW-1:0]] = head;
                    hcnt_d = esu_pkg::HELD_CW'(hcnt_q + 1'b1);
                  end
                end else begin
                  // Broken \033: emit the zero, then replay a held '3' and
                  // this character as plain input.
                  mode_d            = M_PLAIN;
                  hcnt_d            = '0;
                  push              = 1'b1;
                  push_res.out_byte = esu_pkg::ASC_ZERO;
                  if (hcnt_q == esu_pkg::HELD_CW'(3)) begin
                    rep_d[0] = held_q[2];
                    for (int k = 1; k < esu_pkg::REPLAY_DEPTH; k++) begin
                      rep_d[k] = rep_q[k - 1];
                    end
                    rlen_d = esu_pkg::REPLAY_CW'(rlen_q + 1'b1);
                  end else begin
                    rep_d  = rep_q;
                    rlen_d = rlen_q;
                  end
                end
              end
              M_HEX, M_UNI: begin
                if (hcnt_q < esu_pkg::HELD_CW'((uni ? esu_pkg::UNI_DIGITS :
                                                      esu_pkg::HEX_DIGITS) + 1)) begin
                  held_d[hcnt_q[esu_pkg::HELD_AW-1:0]] = head;
                  hcnt_d = esu_pkg::HELD_CW'(hcnt_q + 1'b1);
                end else begin
                  mode_d = M_PLAIN;
                  hcnt_d = '0;
                  push   = 1'b1;
                  ucp_d  = hv;
                  if (!digs[0].hex_ok) begin
                    push_res.byte_valid = 1'b0;
                    push_res.hex_error  = 1'b1;
                  end else if (!uni || hv <= esu_pkg::UTF8_ONE_MAX) begin
                    push_res.out_byte = hv[7:0];
                  end else if (hv <= esu_pkg::UTF8_TWO_MAX) begin
                    push_res.out_byte = esu_pkg::UTF8_LEAD2 | {3'b000, hv[10:6]};
                    emit_d            = 2'd1;
                  end else begin
                    push_res.out_byte = esu_pkg::UTF8_LEAD3 | {4'b0000, hv[15:12]};
                    emit_d            = 2'd2;
                  end
                end
              end
              default: begin
                mode_d = M_PLAIN;
                hcnt_d = '0;
              end
            endcase
          end else if (last_q && hcnt_q != '0) begin
            // End of string inside an escape: emit its letter (or a lone backslash)
            // literally and replay the characters held after it.
            mode_d              = M_PLAIN;
            hcnt_d              = '0;
            push                = 1'b1;
            push_res.byte_valid = 1'b1;
            if (hcnt_q == esu_pkg::HELD_CW'(1)) begin
              push_res.out_byte = esu_pkg::ASC_BSL;
            end else begin
              push_res.out_byte = held_q[1].code;
              for (int k = 0; k < esu_pkg::REPLAY_DEPTH; k++) begin
                if (k + 2 < esu_pkg::HELD_DEPTH) begin
                  rep_d[k] = held_q[k + 2];
                end
              end
              rlen_d = esu_pkg::REPLAY_CW'(hcnt_q - esu_pkg::HELD_CW'(2));
            end
          end else begin
            // Byte finished: release the held result as the last of its run.
            if (pend_vld_q) begin
              enq                = 1'b1;
              enq_res            = pend_q;
              enq_res.run_last   = 1'b1;
              enq_res.string_end = last_q;
            end else if (last_q) begin
              enq                = 1'b1;
              enq_res.run_last   = 1'b1;
              enq_res.string_end = 1'b1;
            end
            pend_vld_d = 1'b0;
            pcnt_d     = '0;
            q_ready    = 1'b1;
            if (q_valid_i) begin
              rep_d[0] = q_item_i.ch;
              rlen_d   = esu_pkg::REPLAY_CW'(1);
              last_d   = q_item_i.last;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Each new result pushes the previous one out; beyond the limit they drop.
    if (push && pcnt_q < esu_pkg::RES_CW'(esu_pkg::MAX_RESULTS)) begin
      if (pend_vld_q) begin
        enq     = 1'b1;
        enq_res = pend_q;
      end
      pend_d     = push_res;
      pend_vld_d = 1'b1;
      pcnt_d     = esu_pkg::RES_CW'(pcnt_q + 1'b1);
    end

    if (enq) begin
      out_vld_d = 1'b1;
      out_d     = enq_res;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= M_PLAIN;
      hcnt_q     <= '0;
      rlen_q     <= '0;
      last_q     <= 1'b0;
      emit_q     <= 2'd0;
      pcnt_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      hcnt_q     <= hcnt_d;
      rlen_q     <= rlen_d;
      last_q     <= last_d;
      emit_q     <= emit_d;
      pcnt_q     <= pcnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      out_q      <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    rep_q  <= rep_d;
    pend_q <= pend_d;
    ucp_q  <= ucp_d;
  end

  assign q_ready_o        = q_ready;
  assign out_o.valid      = out_vld_q;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.byte_valid = out_q.byte_valid;
  assign out_o.run_last   = out_q.run_last;
  assign out_o.string_end = out_q.string_end;
  assign out_o.hex_error  = out_q.hex_error;

endmodule

FILE: design/escape_sequence_unescaper.sv
// Top level of the backslash escape decoder with UTF-8 output.
//
// The block takes a string one character per input beat, with in_last set on
// the final character, and emits the unescaped bytes one per output beat. It
// decodes \033 and \e to ESC, \n, \t, a doubled backslash, \xHH to one byte
// and \uHHHH to one, two or three UTF-8 bytes; \x and \u always take two or
// four characters and use their leading hex digits. A \x or \u whose first
// character is not hex gives one beat with hex_error set and byte_valid
// clear. Any other escaped character is passed through. When the string ends
// inside an escape, the escape letter is emitted literally and the held
// characters are decoded again; a lone trailing backslash is copied. Each
// input character yields zero to four result beats, and the last beat of its
// run carries run_last; the final beat of a string carries string_end, and a
// final character that produced nothing yields one beat with byte_valid
// clear. A front end classifies incoming characters into a two-entry queue,
// so input is taken while the back end works. The back end is a sequencer
// that handles one character or produces one result per cycle, but a full
// output register that is not drained stalls it. Each character is first
// fed from the replay list, then its held result is released as the next
// character is taken; from idle a character is loaded first. Extra UTF-8
// bytes, characters that a broken \033 decodes again and, at the end of a
// string, each flush of a cut-short escape and each replayed held character
// are further steps. There is no clearing pass after reset.
module escape_sequence_unescaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  esu_in_if.sink     in_i,
  esu_out_if.source  out_o
);

  logic            fq_valid;
  logic            fq_ready;
  esu_pkg::item_t  fq_item;
  logic            qb_valid;
  logic            qb_ready;
  esu_pkg::item_t  qb_item;

  // Classification of each incoming beat.
  esu_front u_front (
    .in_i         (in_i),
    .push_valid_o (fq_valid),
    .push_item_o  (fq_item),
    .push_ready_i (fq_ready)
  );

  // Decouples the input side from the decode sequencer.
  esu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_item_i  (fq_item),
    .push_ready_o (fq_ready),
    .pop_valid_o  (qb_valid),
    .pop_item_o   (qb_item),
    .pop_ready_i  (qb_ready)
  );

  // Escape decoding, result grouping and the output register.
  esu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qb_valid),
    .q_item_i  (qb_item),
    .q_ready_o (qb_ready),
    .out_o     (out_o)
  );

endmodule
